// File: hdl/filled_circle_span_generator_defines.svh
// ----------------------------------------------------------------------------
// Filled circle span generator - assertion macros
// Shared macros for the checker of the span generator.
// ----------------------------------------------------------------------------
`ifndef FILLED_CIRCLE_SPAN_GENERATOR_DEFINES_SVH
`define FILLED_CIRCLE_SPAN_GENERATOR_DEFINES_SVH

// same-cycle implication, idle during reset
`define FCSG_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fcsg: implication check failed");

// next-cycle implication, idle during reset
`define FCSG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fcsg: next-cycle check failed");

// state that must hold on the cycle after reset is seen
`define FCSG_ASSERT_RESET(lbl, clk, rst_n, cons) \
    lbl: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
        else $error("fcsg: reset check failed");

`endif

// File: hdl/fcsg_pkg.sv
// ----------------------------------------------------------------------------
// Filled circle span generator - package
// Widths, word types and helpers shared by the front end, job queue and
// span unit.
// ----------------------------------------------------------------------------
package fcsg_pkg;

    localparam int RADIUS_BITS = 13;
    localparam int COLOR_BITS  = 16;
    localparam int COORD_BITS  = 15;
    localparam int DISP_BITS   = 12;
    localparam int CFG_IDX_BITS = 2;

    // centre = corner + radius, never wraps
    localparam int CENTER_BITS =
        ((COORD_BITS > RADIUS_BITS) ? COORD_BITS : (RADIUS_BITS + 1)) + 1;
    localparam int SCOL_BITS = CENTER_BITS + 1;
    localparam int SLEN_BITS = RADIUS_BITS + 1;
    localparam int REND_BITS = SCOL_BITS + 1;
    localparam int DEC_BITS  = RADIUS_BITS + 5;
    localparam int INC_BITS  = RADIUS_BITS + 3;
    localparam int OLEN_BITS = DISP_BITS + 1;

    localparam int SPANS_PER_STEP = 4;
    localparam int IDX_BITS       = $clog2(SPANS_PER_STEP);

    // queue depths, powers of two so pointers wrap by themselves
    localparam int JQ_DEPTH    = 2;
    localparam int JQ_PTR_BITS = $clog2(JQ_DEPTH);
    localparam int OQ_DEPTH    = 2;
    localparam int OQ_PTR_BITS = $clog2(OQ_DEPTH);

    localparam logic [CFG_IDX_BITS-1:0] CFG_DISPLAY_WIDTH  = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] CFG_DISPLAY_HEIGHT = CFG_IDX_BITS'(1);
    localparam logic [DISP_BITS-1:0]    WIDTH_RESET  = DISP_BITS'(320);
    localparam logic [DISP_BITS-1:0]    HEIGHT_RESET = DISP_BITS'(240);

    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    typedef logic signed [CENTER_BITS-1:0] t_center;
    typedef logic        [RADIUS_BITS-1:0] t_offset;
    typedef logic signed [DEC_BITS-1:0]    t_dec;
    typedef logic signed [INC_BITS-1:0]    t_inc;
    typedef logic signed [SCOL_BITS-1:0]   t_scol;
    typedef logic        [SLEN_BITS-1:0]   t_slen;
    typedef logic signed [REND_BITS-1:0]   t_rend;
    typedef logic        [COLOR_BITS-1:0]  t_color;
    typedef logic        [DISP_BITS-1:0]   t_disp;
    typedef logic        [OLEN_BITS-1:0]   t_olen;

    // one classified input word as the span unit sees it
    typedef struct packed {
        logic    single;   // one span only (start or dead step)
        logic    dead;     // step with no walk in progress
        logic    done;
        t_center cx;
        t_center cy;
        t_offset ox;
        t_offset oy;
        t_color  color;
    } t_job;

    // raw, unclipped span
    typedef struct packed {
        t_scol  col;
        t_scol  row;
        t_slen  len;
        t_color color;
        logic   last;
        logic   done;
        logic   dead;
    } t_span;

    typedef struct packed {
        t_disp  column;
        t_disp  row_start;
        t_olen  span_length;
        t_color span_color;
        logic   visible;
        logic   last;
        logic   done_res;
    } t_result;

    typedef struct packed {
        t_disp width;
        t_disp height;
    } t_clip_cfg;

    function automatic t_center off_to_center(t_offset o);
        return t_center'($signed({1'b0, o}));
    endfunction

    function automatic t_scol off_to_scol(t_offset o);
        return t_scol'($signed({1'b0, o}));
    endfunction

endpackage

// File: hdl/fcsg_front.sv
// ----------------------------------------------------------------------------
// Filled circle span generator - front end
// Accepts input words, runs the midpoint recurrence and hands one job word
// per input to the job queue.
// ----------------------------------------------------------------------------
module fcsg_front (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_push,
    input  logic                                  i_full,
    input  logic                                  i_op,
    input  logic signed [fcsg_pkg::COORD_BITS-1:0] i_corner_x,
    input  logic signed [fcsg_pkg::COORD_BITS-1:0] i_corner_y,
    input  logic        [fcsg_pkg::RADIUS_BITS-1:0] i_radius,
    input  logic        [fcsg_pkg::COLOR_BITS-1:0]  i_fill_color,
    output logic                                  o_job_push,
    output fcsg_pkg::t_job                        o_job
);

    fcsg_pkg::t_center r_cx, r_cy, n_cx, n_cy;
    fcsg_pkg::t_dec    r_dec, n_dec;
    fcsg_pkg::t_inc    r_sxi, r_syi, n_sxi, n_syi;
    fcsg_pkg::t_offset r_ox, r_oy, n_ox, n_oy;
    fcsg_pkg::t_color  r_color, n_color;
    logic              r_walk, n_walk;

    logic              accept;
    logic              dec_nonneg;
    fcsg_pkg::t_offset step_ox, step_oy;
    fcsg_pkg::t_inc    step_sxi, step_syi;
    fcsg_pkg::t_dec    step_dec;
    logic              step_walk;
    fcsg_pkg::t_center start_cx, start_cy;

    assign accept = i_push && !i_full;
    assign o_job_push = accept;

    // one recurrence step
    always_comb begin
        dec_nonneg = !r_dec[fcsg_pkg::DEC_BITS-1];
        step_oy    = dec_nonneg ? (r_oy - fcsg_pkg::RADIUS_BITS'(1)) : r_oy;
        step_syi   = dec_nonneg ? (r_syi + fcsg_pkg::t_inc'(2)) : r_syi;
        step_ox    = r_ox + fcsg_pkg::RADIUS_BITS'(1);
        step_sxi   = r_sxi + fcsg_pkg::t_inc'(2);
        step_dec   = r_dec + (dec_nonneg ? fcsg_pkg::t_dec'(step_syi) : fcsg_pkg::t_dec'(0))
                   + fcsg_pkg::t_dec'(step_sxi);
        step_walk  = step_ox < step_oy;
    end

    assign start_cx = fcsg_pkg::t_center'(i_corner_x) + fcsg_pkg::off_to_center(i_radius);
    assign start_cy = fcsg_pkg::t_center'(i_corner_y) + fcsg_pkg::off_to_center(i_radius);

    always_comb begin
        n_cx    = r_cx;
        n_cy    = r_cy;
        n_dec   = r_dec;
        n_sxi   = r_sxi;
        n_syi   = r_syi;
        n_ox    = r_ox;
        n_oy    = r_oy;
        n_color = r_color;
        n_walk  = r_walk;
        o_job   = '0;
        if (i_op == fcsg_pkg::OP_START) begin
            n_cx    = start_cx;
            n_cy    = start_cy;
            n_dec   = fcsg_pkg::t_dec'(1) - fcsg_pkg::t_dec'($signed({1'b0, i_radius}));
            n_sxi   = fcsg_pkg::t_inc'(1);
            n_syi   = fcsg_pkg::t_inc'(0)
                    - (fcsg_pkg::t_inc'($signed({1'b0, i_radius})) <<< 1);
            n_ox    = '0;
            n_oy    = i_radius;
            n_color = i_fill_color;
            n_walk  = (i_radius != '0);
            o_job.single = 1'b1;
            o_job.dead   = 1'b0;
            o_job.done   = (i_radius == '0);
            o_job.cx     = start_cx;
            o_job.cy     = start_cy;
            o_job.ox     = '0;
            o_job.oy     = i_radius;
            o_job.color  = i_fill_color;
        end else if (!r_walk) begin
            // no walk in progress: one blank word marked done
            o_job.single = 1'b1;
            o_job.dead   = 1'b1;
            o_job.done   = 1'b1;
        end else begin
            n_dec   = step_dec;
            n_sxi   = step_sxi;
            n_syi   = step_syi;
            n_ox    = step_ox;
            n_oy    = step_oy;
            n_walk  = step_walk;
            o_job.single = 1'b0;
            o_job.dead   = 1'b0;
            o_job.done   = !step_walk;
            o_job.cx     = r_cx;
            o_job.cy     = r_cy;
            o_job.ox     = step_ox;
            o_job.oy     = step_oy;
            o_job.color  = r_color;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx    <= '0;
            r_cy    <= '0;
            r_dec   <= '0;
            r_sxi   <= fcsg_pkg::t_inc'(1);
            r_syi   <= '0;
            r_ox    <= '0;
            r_oy    <= '0;
            r_color <= '0;
            r_walk  <= 1'b0;
        end else if (accept) begin
            r_cx    <= n_cx;
            r_cy    <= n_cy;
            r_dec   <= n_dec;
            r_sxi   <= n_sxi;
            r_syi   <= n_syi;
            r_ox    <= n_ox;
            r_oy    <= n_oy;
            r_color <= n_color;
            r_walk  <= n_walk;
        end
    end

endmodule

// File: hdl/fcsg_job_queue.sv
// ----------------------------------------------------------------------------
// Filled circle span generator - job queue
// Short first-in first-out queue of job words between front end and span unit.
// ----------------------------------------------------------------------------
module fcsg_job_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  fcsg_pkg::t_job i_data,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_valid,
    output fcsg_pkg::t_job o_data
);

    fcsg_pkg::t_job                      r_mem [fcsg_pkg::JQ_DEPTH];
    logic [fcsg_pkg::JQ_PTR_BITS-1:0]    r_wp, r_rp;
    logic [fcsg_pkg::JQ_PTR_BITS:0]      r_cnt, n_cnt;
    logic                                do_push, do_pop;

    assign o_full  = (r_cnt == (fcsg_pkg::JQ_PTR_BITS+1)'(fcsg_pkg::JQ_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_cnt = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + (fcsg_pkg::JQ_PTR_BITS+1)'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - (fcsg_pkg::JQ_PTR_BITS+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (do_push) begin
                r_wp <= r_wp + fcsg_pkg::JQ_PTR_BITS'(1);
            end
            if (do_pop) begin
                r_rp <= r_rp + fcsg_pkg::JQ_PTR_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

// File: hdl/fcsg_span_unit.sv
// ----------------------------------------------------------------------------
// Filled circle span generator - span unit
// Expands job words into spans, one a cycle while the output queue has room,
// clips them to the display and holds finished results in that small queue.
// ----------------------------------------------------------------------------
module fcsg_span_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_job_valid,
    input  fcsg_pkg::t_job      i_job,
    input  fcsg_pkg::t_clip_cfg i_cfg,
    input  logic                i_pop,
    output logic                o_job_pop,
    output logic                o_empty,
    output fcsg_pkg::t_result   o_result
);

    logic [fcsg_pkg::IDX_BITS-1:0]    r_idx;
    logic                             r_a_valid;
    fcsg_pkg::t_span                  r_a;
    fcsg_pkg::t_span                  a_next;
    logic                             a_load, a_fire;
    fcsg_pkg::t_offset                col_off, row_off;

    fcsg_pkg::t_result                r_oq [fcsg_pkg::OQ_DEPTH];
    logic [fcsg_pkg::OQ_PTR_BITS-1:0] r_wp, r_rp;
    logic [fcsg_pkg::OQ_PTR_BITS:0]   r_cnt, n_cnt;
    logic                             oq_full, do_pop;

    fcsg_pkg::t_rend                  row_end, row_lo, row_hi, h_ext;
    fcsg_pkg::t_scol                  w_ext;
    logic                             vis;
    fcsg_pkg::t_rend                  clip_len;
    fcsg_pkg::t_result                clipped;

    assign oq_full = (r_cnt == (fcsg_pkg::OQ_PTR_BITS+1)'(fcsg_pkg::OQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_pop  = i_pop && !o_empty;
    assign a_fire  = r_a_valid && !oq_full;
    assign a_load  = i_job_valid && (!r_a_valid || a_fire);

    // select span r_idx of the job: odd spans swap the offsets, upper half mirrors
    always_comb begin
        col_off = r_idx[0] ? i_job.oy : i_job.ox;
        row_off = r_idx[0] ? i_job.ox : i_job.oy;
        a_next.col = r_idx[1] ? (fcsg_pkg::t_scol'(i_job.cx) - fcsg_pkg::off_to_scol(col_off))
                              : (fcsg_pkg::t_scol'(i_job.cx) + fcsg_pkg::off_to_scol(col_off));
        a_next.row   = fcsg_pkg::t_scol'(i_job.cy) - fcsg_pkg::off_to_scol(row_off);
        a_next.len   = {row_off, 1'b1};
        a_next.color = i_job.color;
        a_next.last  = i_job.single
                    || (r_idx == fcsg_pkg::IDX_BITS'(fcsg_pkg::SPANS_PER_STEP - 1));
        a_next.done  = i_job.done;
        a_next.dead  = i_job.dead;
    end

    assign o_job_pop = a_load && a_next.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= '0;
            r_a_valid <= 1'b0;
        end else begin
            if (a_load) begin
                r_a_valid <= 1'b1;
                r_idx     <= a_next.last ? '0 : (r_idx + fcsg_pkg::IDX_BITS'(1));
            end else if (a_fire) begin
                r_a_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_load) begin
            r_a <= a_next;
        end
    end

    // clip to the display
    always_comb begin
        h_ext    = fcsg_pkg::t_rend'($signed({1'b0, i_cfg.height}));
        w_ext    = fcsg_pkg::t_scol'($signed({1'b0, i_cfg.width}));
        row_end  = fcsg_pkg::t_rend'(r_a.row) + fcsg_pkg::t_rend'($signed({1'b0, r_a.len}));
        row_lo   = r_a.row[fcsg_pkg::SCOL_BITS-1] ? '0 : fcsg_pkg::t_rend'(r_a.row);
        row_hi   = (row_end > h_ext) ? h_ext : row_end;
        vis      = !r_a.dead && !r_a.col[fcsg_pkg::SCOL_BITS-1] && (r_a.col < w_ext)
                && (row_hi > row_lo);
        clip_len = row_hi - row_lo;
        clipped.column      = vis ? r_a.col[fcsg_pkg::DISP_BITS-1:0] : '0;
        clipped.row_start   = vis ? row_lo[fcsg_pkg::DISP_BITS-1:0] : '0;
        clipped.span_length = vis ? clip_len[fcsg_pkg::OLEN_BITS-1:0] : '0;
        clipped.span_color  = r_a.dead ? '0 : r_a.color;
        clipped.visible     = vis;
        clipped.last        = r_a.last;
        clipped.done_res    = r_a.done;
    end

    always_comb begin
        n_cnt = r_cnt;
        if (a_fire && !do_pop) begin
            n_cnt = r_cnt + (fcsg_pkg::OQ_PTR_BITS+1)'(1);
        end else if (do_pop && !a_fire) begin
            n_cnt = r_cnt - (fcsg_pkg::OQ_PTR_BITS+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (a_fire) begin
                r_wp <= r_wp + fcsg_pkg::OQ_PTR_BITS'(1);
            end
            if (do_pop) begin
                r_rp <= r_rp + fcsg_pkg::OQ_PTR_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_fire) begin
            r_oq[r_wp] <= clipped;
        end
    end

    assign o_result = r_oq[r_rp];

endmodule

// File: hdl/filled_circle_span_generator.sv
// ----------------------------------------------------------------------------
// Filled circle span generator - top level
// Draws a filled circle as clipped vertical spans with the midpoint recurrence.
// ----------------------------------------------------------------------------
// A start word (op 0) loads the circle and yields one result, the centre
// column; a step word (op 1) advances the walk and yields four column spans,
// or one blank word marked done once the walk has ended. The front end takes
// one word a cycle while its two-entry job queue has room; the span unit
// turns out one span a cycle while its two-word output queue has room. A
// word passes the job queue, the span register and the output queue, where
// results wait until popped. The user must write display size through the
// config channel only while the block is idle; the block does not enforce it.
module filled_circle_span_generator (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    push,
    output logic                                    full,
    input  logic                                    i_op,
    input  logic signed [fcsg_pkg::COORD_BITS-1:0]  i_corner_x,
    input  logic signed [fcsg_pkg::COORD_BITS-1:0]  i_corner_y,
    input  logic        [fcsg_pkg::RADIUS_BITS-1:0] i_radius,
    input  logic        [fcsg_pkg::COLOR_BITS-1:0]  i_fill_color,
    output logic                                    empty,
    input  logic                                    pop,
    output logic        [fcsg_pkg::DISP_BITS-1:0]   o_column,
    output logic        [fcsg_pkg::DISP_BITS-1:0]   o_row_start,
    output logic        [fcsg_pkg::OLEN_BITS-1:0]   o_span_length,
    output logic        [fcsg_pkg::COLOR_BITS-1:0]  o_span_color,
    output logic                                    o_visible,
    output logic                                    o_last,
    output logic                                    o_done_res,
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic        [fcsg_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic        [fcsg_pkg::DISP_BITS-1:0]   i_cfg_data
);

    fcsg_pkg::t_clip_cfg r_cfg;
    fcsg_pkg::t_job      front_job, queue_job;
    logic                front_push, queue_valid, queue_pop;
    fcsg_pkg::t_result   result;

    assign o_cfg_ready = 1'b1;

    // indexes past the register list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width  <= fcsg_pkg::WIDTH_RESET;
            r_cfg.height <= fcsg_pkg::HEIGHT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == fcsg_pkg::CFG_DISPLAY_WIDTH) begin
                r_cfg.width <= i_cfg_data;
            end else if (i_cfg_index == fcsg_pkg::CFG_DISPLAY_HEIGHT) begin
                r_cfg.height <= i_cfg_data;
            end
        end
    end

    fcsg_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_full       (full),
        .i_op         (i_op),
        .i_corner_x   (i_corner_x),
        .i_corner_y   (i_corner_y),
        .i_radius     (i_radius),
        .i_fill_color (i_fill_color),
        .o_job_push   (front_push),
        .o_job        (front_job)
    );

    fcsg_job_queue u_job_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_data  (front_job),
        .i_pop   (queue_pop),
        .o_full  (full),
        .o_valid (queue_valid),
        .o_data  (queue_job)
    );

    fcsg_span_unit u_span_unit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (queue_valid),
        .i_job       (queue_job),
        .i_cfg       (r_cfg),
        .i_pop       (pop),
        .o_job_pop   (queue_pop),
        .o_empty     (empty),
        .o_result    (result)
    );

    assign o_column      = result.column;
    assign o_row_start   = result.row_start;
    assign o_span_length = result.span_length;
    assign o_span_color  = result.span_color;
    assign o_visible     = result.visible;
    assign o_last        = result.last;
    assign o_done_res    = result.done_res;

endmodule

// File: hdl/fcsg_checker.sv
// ----------------------------------------------------------------------------
// Filled circle span generator - port checker
// Watches the top level's ports and flags results that break the block's
// rules.
// ----------------------------------------------------------------------------
`include "filled_circle_span_generator_defines.svh"

module fcsg_checker (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    push,
    input  logic                                    full,
    input  logic                                    empty,
    input  logic                                    pop,
    input  logic        [fcsg_pkg::DISP_BITS-1:0]   o_column,
    input  logic        [fcsg_pkg::DISP_BITS-1:0]   o_row_start,
    input  logic        [fcsg_pkg::OLEN_BITS-1:0]   o_span_length,
    input  logic        [fcsg_pkg::COLOR_BITS-1:0]  o_span_color,
    input  logic                                    o_visible,
    input  logic                                    o_last,
    input  logic                                    o_done_res
);

    // nothing waits straight out of reset
    `FCSG_ASSERT_RESET(a_empty_after_reset, i_clk, i_rst_n, empty)

    // a word not taken stays put
    `FCSG_ASSERT_NEXT(a_result_held, i_clk, i_rst_n, !empty && !pop,
        !empty && $stable(o_column) && $stable(o_row_start) && $stable(o_span_length)
        && $stable(o_span_color) && $stable(o_visible) && $stable(o_last)
        && $stable(o_done_res))

    // a blank span carries no position or length
    `FCSG_ASSERT_IMPL(a_blank_zero, i_clk, i_rst_n, !empty && !o_visible, o_column == '0 && o_row_start == '0 && o_span_length == '0)

    // a shown span holds at least one pixel
    `FCSG_ASSERT_IMPL(a_visible_len, i_clk, i_rst_n, !empty && o_visible, o_span_length != '0)

    // the input side only fills up on a pushed word
    `FCSG_ASSERT_NEXT(a_full_needs_push, i_clk, i_rst_n, !push && !full, !full)

endmodule

bind filled_circle_span_generator fcsg_checker u_checker (.*);

// File: sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Filled circle span generator - testbench
// Sends start and step words for filled circles and predicts every clipped
// column span from an in-bench copy of the midpoint recurrence. Each popped
// result is checked field by field against the oldest prediction. The run
// covers several display sizes, random idling on both sides and a long
// output stall.
// ----------------------------------------------------------------------------
module tb;
    import fcsg_pkg::*;

    localparam int LONG_HOLD      = 300;
    localparam int SETTLE_CYCLES  = 6;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED_A = CFG_IDX_BITS'(2);
    localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED_B = CFG_IDX_BITS'(3);

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           push;
    logic                           full;
    logic                           i_op;
    logic signed [COORD_BITS-1:0]   i_corner_x;
    logic signed [COORD_BITS-1:0]   i_corner_y;
    logic        [RADIUS_BITS-1:0]  i_radius;
    logic        [COLOR_BITS-1:0]   i_fill_color;
    logic                           empty;
    logic                           pop;
    logic        [DISP_BITS-1:0]    o_column;
    logic        [DISP_BITS-1:0]    o_row_start;
    logic        [OLEN_BITS-1:0]    o_span_length;
    logic        [COLOR_BITS-1:0]   o_span_color;
    logic                           o_visible;
    logic                           o_last;
    logic                           o_done_res;
    logic                           i_cfg_valid;
    logic                           o_cfg_ready;
    logic        [CFG_IDX_BITS-1:0] i_cfg_index;
    logic        [DISP_BITS-1:0]    i_cfg_data;

    filled_circle_span_generator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_op          (i_op),
        .i_corner_x    (i_corner_x),
        .i_corner_y    (i_corner_y),
        .i_radius      (i_radius),
        .i_fill_color  (i_fill_color),
        .empty         (empty),
        .pop           (pop),
        .o_column      (o_column),
        .o_row_start   (o_row_start),
        .o_span_length (o_span_length),
        .o_span_color  (o_span_color),
        .o_visible     (o_visible),
        .o_last        (o_last),
        .o_done_res    (o_done_res),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // circle walk state as the block should hold it
    int      disp_w = int'(WIDTH_RESET);
    int      disp_h = int'(HEIGHT_RESET);
    int      cen_x = 0;
    int      cen_y = 0;
    int      dec_term = 0;
    int      inc_x = 1;
    int      inc_y = 0;
    int      off_x = 0;
    int      off_y = 0;
    t_color  cur_color = '0;
    bit      walking = 1'b0;

    t_result pending_spans[$];
    int      mismatch_count = 0;
    int      words_sent = 0;
    int      quiet_cycles = 0;
    bit      sender_gaps = 1'b1;
    bit      hold_results_req = 1'b0;
    bit      results_held = 1'b0;

    // ------------------------------------------------------------------------
    // span prediction
    // ------------------------------------------------------------------------
    function automatic void queue_span(int col, int row, int len, logic last_word);
        t_result s;
        int      top;
        int      bottom;
        logic    shown;
        top    = (row < 0) ? 0 : row;
        bottom = row + len;
        if (bottom > disp_h) begin
            bottom = disp_h;
        end
        shown = (col >= 0) && (col < disp_w) && (bottom > top);
        s.column      = shown ? t_disp'(col) : '0;
        s.row_start   = shown ? t_disp'(top) : '0;
        s.span_length = shown ? t_olen'(bottom - top) : '0;
        s.span_color  = cur_color;
        s.visible     = shown;
        s.last        = last_word;
        s.done_res    = !walking;
        pending_spans.push_back(s);
    endfunction

    function automatic void predict_spans(logic op, logic signed [COORD_BITS-1:0] cxw,
                                          logic signed [COORD_BITS-1:0] cyw,
                                          logic [RADIUS_BITS-1:0] rw, t_color colw);
        int      rad;
        t_result blank;
        if (op == OP_START) begin
            rad       = int'(rw);
            cen_x     = int'(cxw) + rad;
            cen_y     = int'(cyw) + rad;
            dec_term  = 1 - rad;
            inc_x     = 1;
            inc_y     = -2 * rad;
            off_x     = 0;
            off_y     = rad;
            cur_color = colw;
            walking   = (rad > 0);
            queue_span(cen_x, cen_y - rad, 2 * rad + 1, 1'b1);
        end else if (!walking) begin
            // walk over: one blank word flagged done
            blank          = '0;
            blank.last     = 1'b1;
            blank.done_res = 1'b1;
            pending_spans.push_back(blank);
        end else begin
            if (dec_term >= 0) begin
                off_y    -= 1;
                inc_y    += 2;
                dec_term += inc_y;
            end
            off_x    += 1;
            inc_x    += 2;
            dec_term += inc_x;
            walking   = (off_x < off_y);
            queue_span(cen_x + off_x, cen_y - off_y, 2 * off_y + 1, 1'b0);
            queue_span(cen_x + off_y, cen_y - off_x, 2 * off_x + 1, 1'b0);
            queue_span(cen_x - off_x, cen_y - off_y, 2 * off_y + 1, 1'b0);
            queue_span(cen_x - off_y, cen_y - off_x, 2 * off_x + 1, 1'b1);
        end
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            return 0;
        end
        if (roll < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------
    task automatic send_word(input logic op, input int cx, input int cy, input int rad,
                             input int colour);
        int gap;
        gap = sender_gaps ? pick_gap() : 0;
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push         <= 1'b1;
        i_op         <= op;
        i_corner_x   <= cx[COORD_BITS-1:0];
        i_corner_y   <= cy[COORD_BITS-1:0];
        i_radius     <= rad[RADIUS_BITS-1:0];
        i_fill_color <= colour[COLOR_BITS-1:0];
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        predict_spans(op, cx[COORD_BITS-1:0], cy[COORD_BITS-1:0], rad[RADIUS_BITS-1:0],
                      colour[COLOR_BITS-1:0]);
        words_sent++;
    endtask

    // hold input until every predicted word has been popped
    task automatic settle_block();
        push <= 1'b0;
        while (pending_spans.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // leaves valid high; the caller drops it after its last write
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input int value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value[DISP_BITS-1:0];
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == CFG_DISPLAY_WIDTH) begin
            disp_w = value & 'hFFF;
        end else if (idx == CFG_DISPLAY_HEIGHT) begin
            disp_h = value & 'hFFF;
        end
    endtask

    task automatic configure(input int width, input int height);
        settle_block();
        write_reg(CFG_DISPLAY_WIDTH, width);
        write_reg(CFG_DISPLAY_HEIGHT, height);
        i_cfg_valid <= 1'b0;
    endtask

    // start word, then steps; past the end of the walk, stop now and then
    task automatic run_circle(input int cx, input int cy, input int rad, input int max_steps);
        int k;
        send_word(OP_START, cx, cy, rad, $urandom_range(0, 65535));
        for (k = 0; k < max_steps; k++) begin
            if (!walking && $urandom_range(0, 2) != 0) begin
                break;
            end
            send_word(OP_STEP, $urandom_range(0, 32767), $urandom_range(0, 32767),
                      $urandom_range(0, 8191), $urandom_range(0, 65535));
        end
    endtask

    task automatic random_circles(input int n_words);
        int stop_at;
        int roll;
        int rad;
        int cx;
        int cy;
        stop_at = words_sent + n_words;
        while (words_sent < stop_at) begin
            roll        = $urandom_range(0, 99);
            sender_gaps = ($urandom_range(0, 4) != 0);
            if (roll < 70) begin
                rad = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 24);
                cx  = int'($urandom_range(0, disp_w + 40)) - 30 - rad;
                cy  = int'($urandom_range(0, disp_h + 40)) - 30 - rad;
                if ($urandom_range(0, 4) == 0) begin
                    run_circle(cx, cy, rad, $urandom_range(0, rad));
                end else begin
                    run_circle(cx, cy, rad, rad + 2);
                end
            end else if (roll < 82) begin
                run_circle($urandom_range(0, 32767), $urandom_range(0, 32767),
                           $urandom_range(0, 8191), $urandom_range(1, 3));
            end else begin
                send_word(logic'($urandom_range(0, 1)), $urandom_range(0, 32767),
                          $urandom_range(0, 32767), $urandom_range(0, 8191),
                          $urandom_range(0, 65535));
            end
        end
        sender_gaps = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_step_without_circle();
        send_word(OP_STEP, 16383, -16384, 8191, 65535);
    endtask

    task automatic test_zero_radius();
        send_word(OP_START, 100, 100, 0, 16'h0000);
        send_word(OP_STEP, 0, 0, 0, 0);
    endtask

    task automatic test_small_walk();
        send_word(OP_START, 10, 20, 3, 16'hFFFF);
        while (walking) send_word(OP_STEP, 0, 0, 0, 0);
        send_word(OP_STEP, 0, 0, 0, 0);
        run_circle(50, 60, 1, 2);
    endtask

    task automatic test_edge_clipping();
        // off the left and top edges, then past the right and bottom ones
        run_circle(-4, -3, 6, 2);
        run_circle(disp_w - 5, disp_h - 5, 8, 2);
    endtask

    task automatic test_field_extremes();
        send_word(OP_START, -16384, -16384, 8191, 16'hAAAA);
        send_word(OP_STEP, 0, 0, 0, 0);
        send_word(OP_START, 16383, 16383, 8191, 16'h5555);
        send_word(OP_STEP, 0, 0, 0, 0);
    endtask

    task automatic test_large_display();
        configure(4095, 4095);
        run_circle(3900, 3950, 300, 6);
        random_circles(25);
    endtask

    task automatic test_single_pixel_display();
        configure(1, 1);
        run_circle(-2, -2, 2, 4);
        random_circles(15);
    endtask

    task automatic test_zero_display();
        configure(0, 0);
        random_circles(12);
    endtask

    task automatic test_spare_registers();
        settle_block();
        write_reg(CFG_UNUSED_A, $urandom_range(0, 4095));
        write_reg(CFG_UNUSED_B, 4095);
        i_cfg_valid <= 1'b0;
        random_circles(10);
    endtask

    task automatic test_output_backpressure();
        configure(64, 48);
        hold_results_req = 1'b1;
        while (!results_held) @(posedge i_clk);
        // offer words without gaps so the block fills and stalls its input
        sender_gaps = 1'b0;
        run_circle(10, 5, 20, 14);
        sender_gaps = 1'b1;
        while (hold_results_req) @(posedge i_clk);
        settle_block();
    endtask

    task automatic test_random_mix();
        configure(100, 80);
        random_circles(60);
        configure(4095, 1);
        random_circles(30);
        configure(1, 4095);
        random_circles(30);
    endtask

    initial begin : test_sequence
        i_rst_n      = 1'b0;
        push         = 1'b0;
        i_op         = OP_START;
        i_corner_x   = '0;
        i_corner_y   = '0;
        i_radius     = '0;
        i_fill_color = '0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = CFG_DISPLAY_WIDTH;
        i_cfg_data   = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_step_without_circle();
        test_zero_radius();
        test_small_walk();
        test_edge_clipping();
        test_field_extremes();
        test_large_display();
        test_single_pixel_display();
        test_zero_display();
        test_spare_registers();
        test_output_backpressure();
        test_random_mix();

        settle_block();
        repeat (12) @(posedge i_clk);
        if (pending_spans.size() != 0) begin
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("filled_circle_span_generator test passed");
        end else begin
            $display("filled_circle_span_generator test failed");
        end
        $finish;
    end

    // result side: random pops, plus one long hold-off on request
    initial begin : result_sink
        int run;
        pop = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_results_req) begin
                pop <= 1'b0;
                results_held = 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
                results_held     = 1'b0;
                hold_results_req = 1'b0;
            end else begin
                run = pick_gap();
                if (run == 0) begin
                    pop <= 1'b1;
                    run = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 12);
                end else begin
                    pop <= 1'b0;
                end
                repeat (run) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin : span_checker
        t_result want;
        t_result got;
        logic    bad;
        if (i_rst_n && pop && !empty) begin
            got.column      = o_column;
            got.row_start   = o_row_start;
            got.span_length = o_span_length;
            got.span_color  = o_span_color;
            got.visible     = o_visible;
            got.last        = o_last;
            got.done_res    = o_done_res;
            if (pending_spans.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("unexpected span word: col %0d row %0d len %0d colour %h",
                             got.column, got.row_start, got.span_length, got.span_color);
                end
            end else begin
                want = pending_spans.pop_front();
                bad  = (got.column !== want.column) || (got.row_start !== want.row_start) ||
                       (got.span_length !== want.span_length) ||
                       (got.span_color !== want.span_color) ||
                       (got.visible !== want.visible) || (got.last !== want.last) ||
                       (got.done_res !== want.done_res);
                if (bad) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $write("span mismatch: expected col %0d row %0d len %0d colour %h",
                               want.column, want.row_start, want.span_length,
                               want.span_color);
                        $display(" vis %b last %b done %b", want.visible, want.last,
                                 want.done_res);
                        $write("               got      col %0d row %0d len %0d colour %h",
                               got.column, got.row_start, got.span_length,
                               got.span_color);
                        $display(" vis %b last %b done %b", got.visible, got.last,
                                 got.done_res);
                    end
                end
            end
        end
    end

    // count cycles in which no word moves on any channel
    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("filled_circle_span_generator test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

// File: sim.f
+incdir+hdl
hdl/fcsg_pkg.sv
hdl/fcsg_front.sv
hdl/fcsg_job_queue.sv
hdl/fcsg_span_unit.sv
hdl/filled_circle_span_generator.sv
hdl/fcsg_checker.sv
sim/tb.sv
